[rtl/core/llwv_pkg.sv]
// llwv_pkg: shared types and constants for the log-law wall viscosity block.
// No dependencies.
package llwv_pkg;
   localparam int unsigned WORD_W = 48;
   typedef logic [WORD_W-1:0] word_type;
   localparam word_type MAXV = '1;
   localparam logic [47:0] LN2_Q48 = 48'hB17217F7D1CF;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KAPPA = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_E = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAMINAR = 2'd2;

   typedef enum logic [1:0] {
      OP_MUL, OP_DIV, OP_LN
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic [5:0] shift;
   } alu_cmd_type;
endpackage

[rtl/core/log_law_wall_viscosity.sv]
// log_law_wall_viscosity: top level, sequencer around the shared arithmetic unit.
// Depends on llwv_pkg and llwv_alu.
//
//  channel | dir | contents
//  req_    | in  | tdata: velocity_magnitude, wall_distance, wall_density, wall_viscosity
//  rsp_    | out | tdata: y_plus, turbulent_viscosity
//  csr_    | in  | index 0 kappa, 1 E, 2 laminar limit
//
// The kRe step is three products and a divide; each iteration is a product, a log,
// a divide and a check, up to MAX_ITERATIONS of them, then a tail of products, a log
// and a divide, all on the shared unit. Synchronous active-high reset idles
// the sequencer and reloads the register defaults. A request is taken whenever
// the sequencer is idle; a finished result waits only while the previous one is held.
module log_law_wall_viscosity #(
   parameter int MAX_ITERATIONS = 10,
   parameter int FRACTION_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // velocity_magnitude, wall_distance, wall_density, wall_viscosity
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // y_plus, turbulent_viscosity
   input  logic         csr_we,
   input  logic [llwv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [47:0]  csr_wdata
);
   import llwv_pkg::*;

   localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_K1, S_K2, S_K3, S_K4, S_IT_EY, S_IT_LN, S_IT_DIV, S_IT_CHK,
      S_T_EY, S_T_LN, S_T_M, S_T_DIV, S_T_MU, S_OUT
   } state_type;

   state_type state_ff;
   word_type kappa_ff, e_ff, lam_ff;
   word_type u_ff, y_ff, rho_ff, mu_ff, kre_ff, yp_ff, last_ff, mut_ff;
   word_type rsp_yp_ff, rsp_mut_ff;
   logic [63:0] t_ff;
   logic [63:0] lnv_ff;
   logic [6:0] iter_ff;
   logic issued_ff;
   alu_cmd_type cmd;
   logic [63:0] op_a, op_b, res;
   logic done, lneg;
   logic [63:0] den, sum, diff;

   llwv_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
      .clock, .reset, .cmd, .op_a, .op_b, .done, .result(res), .neg(lneg)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign sum = 64'(kre_ff) + 64'(yp_ff);
   assign diff = (yp_ff > last_ff) ? 64'(yp_ff - last_ff) : 64'(last_ff - yp_ff);
   // 1 + ln(E*y+) from the signed log result
   assign den = lneg ? ONE - res : ONE + res;

   always_comb begin
      cmd = '{start: 1'b0, op: OP_MUL, shift: 6'(FRACTION_BITS)};
      op_a = '0; op_b = '0;
      case (state_ff)
         S_K1: begin op_a = 64'(kappa_ff); op_b = 64'(u_ff); end
         S_K2: begin op_a = 64'(kre_ff); op_b = 64'(y_ff); end
         S_K3: begin op_a = 64'(kre_ff); op_b = 64'(rho_ff); end
         S_K4: begin cmd.op = OP_DIV; op_a = 64'(kre_ff); op_b = 64'(mu_ff); end
         S_IT_EY, S_T_EY: begin op_a = 64'(e_ff); op_b = 64'(yp_ff); end
         S_IT_LN, S_T_LN: begin cmd.op = OP_LN; op_a = t_ff; end
         S_IT_DIV: begin
            cmd.op = OP_DIV;
            op_a = (sum > 64'(MAXV)) ? 64'(MAXV) : sum; op_b = t_ff;
         end
         S_T_M: begin op_a = 64'(yp_ff); op_b = 64'(kappa_ff); end
         S_T_DIV: begin cmd.op = OP_DIV; op_a = t_ff; op_b = lnv_ff; end
         S_T_MU: begin op_a = 64'(mu_ff); op_b = t_ff - ONE; end
         default: ;
      endcase
      cmd.start = !issued_ff && state_ff != S_IDLE && state_ff != S_OUT
                  && state_ff != S_IT_CHK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_tvalid <= 1'b0; issued_ff <= 1'b0;
         kappa_ff <= 48'd1760936591; e_ff <= 48'd42090679501;
         lam_ff <= 48'd49520972923;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KAPPA: kappa_ff <= csr_wdata;
               CSR_E: e_ff <= csr_wdata;
               CSR_LAMINAR: lam_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_OUT && (!rsp_tvalid || rsp_tready)) rsp_tvalid <= 1'b1;
         else if (rsp_tready) rsp_tvalid <= 1'b0;
         if (cmd.start) issued_ff <= 1'b1;
         if (done) issued_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               u_ff <= req_tdata[47:0]; y_ff <= req_tdata[95:48];
               rho_ff <= req_tdata[143:96]; mu_ff <= req_tdata[191:144];
               mut_ff <= '0; iter_ff <= '0;
               state_ff <= S_K1;
            end
            S_K1, S_K2, S_K3: if (done) begin
               kre_ff <= res[47:0];
               state_ff <= state_type'(state_ff + 5'd1);
            end
            S_K4: if (done) begin
               kre_ff <= res[47:0]; yp_ff <= lam_ff; state_ff <= S_IT_EY;
            end
            S_IT_EY: if (done) begin
               last_ff <= yp_ff; t_ff <= res;
               if (res == 64'd0) begin yp_ff <= MAXV; state_ff <= S_IT_CHK; end
               else state_ff <= S_IT_LN;
            end
            S_IT_LN: if (done) begin
               if (den == 64'd0 || den[63]) begin
                  yp_ff <= MAXV; state_ff <= S_IT_CHK;
               end else begin
                  t_ff <= den; state_ff <= S_IT_DIV;
               end
            end
            S_IT_DIV: if (done) begin
               yp_ff <= res[47:0]; state_ff <= S_IT_CHK;
            end
            S_IT_CHK: begin
               iter_ff <= iter_ff + 7'd1;
               if ((diff * 64'd100) > 64'(lam_ff) && iter_ff + 7'd1 < 7'(MAX_ITERATIONS))
                  state_ff <= S_IT_EY;
               else if (yp_ff > lam_ff) state_ff <= S_T_EY;
               else state_ff <= S_OUT;
            end
            S_T_EY: if (done) begin
               t_ff <= res;
               state_ff <= (res == 64'd0) ? S_OUT : S_T_LN;
            end
            S_T_LN: if (done) begin
               // ln magnitude kept for the tail divide
               if (lneg || res == 64'd0) state_ff <= S_OUT;
               else begin lnv_ff <= res; state_ff <= S_T_M; end
            end
            S_T_M: if (done) begin
               t_ff <= res; state_ff <= S_T_DIV;
            end
            S_T_DIV: if (done) begin
               t_ff <= res;
               state_ff <= (res > ONE) ? S_T_MU : S_OUT;
            end
            S_T_MU: if (done) begin
               mut_ff <= res[47:0]; state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_tvalid || rsp_tready) begin
               rsp_yp_ff <= yp_ff; rsp_mut_ff <= mut_ff; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tdata = {rsp_mut_ff, rsp_yp_ff};
endmodule

[rtl/core/llwv_alu.sv]
// llwv_alu: shared multi-cycle multiply / divide / logarithm unit.
// Depends on llwv_pkg.
module llwv_alu #(
   parameter int FRACTION_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  llwv_pkg::alu_cmd_type cmd,
   input  logic [63:0]           op_a,
   input  logic [63:0]           op_b,
   output logic                  done,
   output logic [63:0]           result,
   output logic                  neg
);
   import llwv_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_DIV, S_LNORM, S_LSQ, S_LMUL, S_DONE
   } state_type;

   state_type   state_ff;
   logic [1:0]  mcnt_ff;
   logic [127:0] acc_ff;
   logic [63:0] a_ff, b_ff;
   logic [5:0]  sh_ff;
   logic [6:0]  cnt_ff;
   logic [63:0] q_ff, r_ff;
   logic        ovf_ff;
   logic [63:0] m_ff, frac_ff;
   logic [5:0]  p_ff;
   logic        neg_ff;
   logic [63:0] res_ff;
   logic        lnmul_ff;

   logic [63:0] mul_opb;
   logic [31:0] pa;
   logic [63:0] pprod;
   logic [127:0] shifted;
   logic [64:0] r_sh;
   logic [63:0] msq;

   always_comb begin
      pa = a_ff[32*mcnt_ff[1] +: 32];
      mul_opb = b_ff;
      pprod = 64'(pa) * 64'(mul_opb[32*mcnt_ff[0] +: 32]);
      shifted = acc_ff >> sh_ff;
      // next dividend bit enters before the compare
      r_sh = {r_ff, a_ff[47]};
      msq = (64'(m_ff[31:0]) * 64'(m_ff[31:0])) >> 31;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd.start) begin
                  a_ff <= op_a; b_ff <= op_b; sh_ff <= cmd.shift;
                  acc_ff <= '0; mcnt_ff <= '0; lnmul_ff <= 1'b0;
                  case (cmd.op)
                     OP_MUL: state_ff <= S_MUL;
                     OP_DIV: begin
                        if (op_b == 64'd0) begin
                           res_ff <= 64'(MAXV); state_ff <= S_DONE;
                        end else begin
                           q_ff <= '0; r_ff <= '0; cnt_ff <= 7'd0; ovf_ff <= 1'b0;
                           state_ff <= S_DIV;
                        end
                     end
                     OP_LN: begin
                        p_ff <= 6'd47; state_ff <= S_LNORM;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_MUL: begin
               acc_ff <= acc_ff + (128'(pprod) << (32*(mcnt_ff[0] + mcnt_ff[1])));
               mcnt_ff <= mcnt_ff + 2'd1;
               if (mcnt_ff == 2'd3) state_ff <= S_LMUL;
            end
            S_LMUL: begin
               // saturating shift of the product
               if (shifted > 128'(MAXV)) res_ff <= 64'(MAXV);
               else res_ff <= shifted[63:0];
               state_ff <= S_DONE;
            end
            S_DIV: begin
               // restoring division of (a << F) by b, 48+F quotient bits
               if (r_sh >= 65'(b_ff)) begin
                  r_ff <= 64'(r_sh - 65'(b_ff));
                  q_ff <= {q_ff[62:0], 1'b1};
               end else begin
                  r_ff <= r_sh[63:0];
                  q_ff <= {q_ff[62:0], 1'b0};
               end
               // quotient bit leaving the 48-bit range marks saturation
               if (q_ff[47]) ovf_ff <= 1'b1;
               a_ff <= {a_ff[62:0], 1'b0};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(48 + FRACTION_BITS - 1)) state_ff <= S_LSQ;
            end
            S_LNORM: begin
               if (p_ff != 6'd0 && !a_ff[p_ff]) p_ff <= p_ff - 6'd1;
               else begin
                  m_ff <= (p_ff >= 6'd31) ? (a_ff >> (p_ff - 6'd31))
                                          : (a_ff << (6'd31 - p_ff));
                  frac_ff <= '0; cnt_ff <= 7'd1; lnmul_ff <= 1'b1;
                  state_ff <= S_LSQ;
               end
            end
            S_LSQ: begin
               if (!lnmul_ff) begin
                  // division wrap-up: quotient saturate
                  if (ovf_ff || q_ff[63:48] != 16'd0) res_ff <= 64'(MAXV);
                  else res_ff <= q_ff;
                  state_ff <= S_DONE;
               end else if (cnt_ff <= 7'(FRACTION_BITS)) begin
                  if (msq[32]) begin
                     m_ff <= msq >> 1;
                     frac_ff <= frac_ff | (64'd1 << (7'(FRACTION_BITS) - cnt_ff));
                  end else m_ff <= msq;
                  cnt_ff <= cnt_ff + 7'd1;
               end else begin
                  // signed log2, then magnitude times ln2
                  logic signed [63:0] l2;
                  l2 = ($signed(64'(p_ff)) - 64'(FRACTION_BITS)) * (64'sd1 <<< FRACTION_BITS)
                       + $signed(frac_ff);
                  neg_ff <= l2[63];
                  a_ff <= l2[63] ? 64'(-l2) : 64'(l2);
                  b_ff <= 64'(LN2_Q48);
                  sh_ff <= 6'd48; acc_ff <= '0; mcnt_ff <= '0;
                  lnmul_ff <= 1'b0;
                  state_ff <= S_MUL;
               end
            end
            S_DONE: begin
               done <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_IDLE && cmd.start) neg_ff <= 1'b0;
      end
   end

   assign result = res_ff;
   assign neg = neg_ff;
endmodule
